### rtl/rps_pkg.sv
// shared types, codes and constants of the relay power sequencer
`default_nettype none
package rps_pkg;

  // item kinds carried on tuser
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_ENABLE  = 3'd1;
  localparam logic [2:0] KIND_DISABLE = 3'd2;
  localparam logic [2:0] KIND_ESTOP   = 3'd3;
  localparam logic [2:0] KIND_LIGHTS  = 3'd4;
  localparam logic [2:0] KIND_MEDIA   = 3'd5;
  localparam logic [2:0] KIND_INIT    = 3'd6;

  // sequence steps
  localparam logic [3:0] SEQ_REST      = 4'd0;
  localparam logic [3:0] SEQ_EN_MAIN   = 4'd1;
  localparam logic [3:0] SEQ_EN_TRAC   = 4'd2;
  localparam logic [3:0] SEQ_EN_STEER  = 4'd3;
  localparam logic [3:0] SEQ_EN_END    = 4'd4;
  localparam logic [3:0] SEQ_DIS_STEER = 4'd5;
  localparam logic [3:0] SEQ_DIS_TRAC  = 4'd6;
  localparam logic [3:0] SEQ_DIS_MAIN  = 4'd7;
  localparam logic [3:0] SEQ_DIS_END   = 4'd8;

  // request status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NO_INIT  = 3'd1;
  localparam logic [2:0] STAT_SYS_ERR  = 3'd2;
  localparam logic [2:0] STAT_DEBOUNCE = 3'd3;
  localparam logic [2:0] STAT_ALREADY  = 3'd4;
  localparam logic [2:0] STAT_BUSY     = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_OVERCURRENT = 3'd0;
  localparam logic [2:0] REG_VOLT_LOW    = 3'd1;
  localparam logic [2:0] REG_VOLT_HIGH   = 3'd2;
  localparam logic [2:0] REG_OVERTEMP    = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd4;
  localparam logic [2:0] REG_EN_STEP     = 3'd5;
  localparam logic [2:0] REG_DIS_STEP    = 3'd6;
  localparam logic [2:0] REG_TIMEOUT     = 3'd7;

  localparam int CFG_W  = 17;
  localparam int IN_W   = 160;
  localparam int OUT_W  = 24;

  // relay bit positions
  localparam int RLY_MAIN  = 0;
  localparam int RLY_TRAC  = 1;
  localparam int RLY_STEER = 2;
  localparam int RLY_LIGHT = 3;
  localparam int RLY_MEDIA = 4;
  localparam logic [4:0] RELAY_POWER = 5'b00111;

  localparam int MotorFields  = 4;
  localparam int MotorSensors = 4;

  localparam logic signed [19:0] NoReading    = -20'sd524288;
  localparam logic signed [19:0] CurrentCeil  = 20'sd100000;
  localparam logic signed [19:0] TempCeil     = 20'sd10000;
  localparam logic signed [19:0] VoltCeil     = 20'sd10000;
  localparam int                 FaultClearMs = 1000;
  localparam logic [7:0]         FaultRunMin  = 8'd3;
  localparam logic [7:0]         FaultRunMax  = 8'd255;

  typedef struct packed {
    logic [16:0] overcurrent_limit;
    logic [13:0] voltage_low_limit;
    logic [13:0] voltage_high_limit;
    logic [13:0] overtemp_limit;
    logic [15:0] debounce_ms;
    logic [15:0] enable_step_ms;
    logic [15:0] disable_step_ms;
    logic [15:0] step_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                   kind;
    logic [31:0]                  now_ms;
    logic                         system_has_error;
    logic                         switch_on;
    logic signed [19:0]           battery_current;
    logic signed [19:0]           battery_voltage;
    logic [MotorFields-1:0][19:0] motor_temp;
  } item_t;

  typedef struct packed {
    logic       critical_shutdown;
    logic       emergency_logged;
    logic       timeout_fired;
    logic [6:0] fault_mask;
    logic [2:0] request_status;
    logic [3:0] sequence_step;
    logic       media_on;
    logic       lights_on;
    logic       steering_on;
    logic       traction_on;
    logic       main_on;
  } result_t;

endpackage
`default_nettype wire

### rtl/rps_cfg_regs.sv
// configuration register file of the relay power sequencer
`default_nettype none
module rps_cfg_regs
  import rps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.overcurrent_limit  <= 17'd1200;
      cfg.voltage_low_limit  <= 14'd200;
      cfg.voltage_high_limit <= 14'd300;
      cfg.overtemp_limit     <= 14'd800;
      cfg.debounce_ms        <= 16'd50;
      cfg.enable_step_ms     <= 16'd50;
      cfg.disable_step_ms    <= 16'd20;
      cfg.step_timeout_ms    <= 16'd5000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OVERCURRENT: cfg.overcurrent_limit  <= cfg_data[16:0];
        REG_VOLT_LOW:    cfg.voltage_low_limit  <= cfg_data[13:0];
        REG_VOLT_HIGH:   cfg.voltage_high_limit <= cfg_data[13:0];
        REG_OVERTEMP:    cfg.overtemp_limit     <= cfg_data[13:0];
        REG_DEBOUNCE:    cfg.debounce_ms        <= cfg_data[15:0];
        REG_EN_STEP:     cfg.enable_step_ms     <= cfg_data[15:0];
        REG_DIS_STEP:    cfg.disable_step_ms    <= cfg_data[15:0];
        REG_TIMEOUT:     cfg.step_timeout_ms    <= cfg_data[15:0];
        default:         cfg.step_timeout_ms    <= cfg.step_timeout_ms;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/rps_fault_check.sv
// sensor limit checks that build the fault mask of a tick
`default_nettype none
module rps_fault_check
  import rps_pkg::*;
(
  input  wire cfg_t  cfg,
  input  wire item_t item,
  output logic [6:0] fault_mask
);

  logic signed [19:0] cur_lim;
  logic signed [19:0] temp_lim;
  logic signed [19:0] vlow_lim;
  logic signed [19:0] vhigh_lim;
  logic signed [19:0] temp;

  assign cur_lim   = $signed({3'b000, cfg.overcurrent_limit});
  assign temp_lim  = $signed({6'b000000, cfg.overtemp_limit});
  assign vlow_lim  = $signed({6'b000000, cfg.voltage_low_limit});
  assign vhigh_lim = $signed({6'b000000, cfg.voltage_high_limit});

  always_comb begin
    fault_mask = '0;
    temp = '0;
    // limits are never negative, so a missing reading never passes a > test
    fault_mask[0] = (item.battery_current != NoReading) &&
                    (item.battery_current > cur_lim) &&
                    (item.battery_current < CurrentCeil);
    for (int i = 0; i < MotorFields; i++) begin
      temp = $signed(item.motor_temp[i]);
      if (i < MotorSensors) begin
        fault_mask[1+i] = (temp != NoReading) && (temp > temp_lim) && (temp < TempCeil);
      end
    end
    if (item.battery_voltage > 20'sd0) begin
      if (item.battery_voltage < vlow_lim) begin
        fault_mask[5] = 1'b1;
      end else if ((item.battery_voltage > vhigh_lim) && (item.battery_voltage < VoltCeil)) begin
        fault_mask[6] = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/rps_seq_core.sv
// sequencer state, request handling and tick processing for one item
`default_nettype none
module rps_seq_core
  import rps_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       go,
  input  wire cfg_t       cfg,
  input  wire item_t      item,
  input  wire logic [6:0] sensor_mask,
  output result_t         result
);

  logic                 initialized;
  logic [3:0]           seq;
  logic [TIME_BITS-1:0] step_start;
  logic [TIME_BITS-1:0] last_change;
  logic [4:0]           relays;
  logic                 emerg_pending;
  logic [7:0]           fault_count;
  logic [TIME_BITS-1:0] last_fault;

  logic                 initialized_next;
  logic [3:0]           seq_next;
  logic [TIME_BITS-1:0] step_start_next;
  logic [TIME_BITS-1:0] last_change_next;
  logic [4:0]           relays_next;
  logic                 emerg_pending_next;
  logic [7:0]           fault_count_next;
  logic [TIME_BITS-1:0] last_fault_next;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] step_age;
  logic [TIME_BITS-1:0] change_age;
  logic [TIME_BITS-1:0] fault_age;
  logic [2:0]           status;
  logic [6:0]           mask;
  logic                 tmo;
  logic                 emerg_log;
  logic                 crit;

  assign now        = TIME_BITS'(item.now_ms);
  assign step_age   = now - step_start;
  assign change_age = now - last_change;
  assign fault_age  = now - last_fault;

  always_comb begin
    initialized_next   = initialized;
    seq_next           = seq;
    step_start_next    = step_start;
    last_change_next   = last_change;
    relays_next        = relays;
    emerg_pending_next = emerg_pending;
    fault_count_next   = fault_count;
    last_fault_next    = last_fault;
    status             = STAT_OK;
    mask               = '0;
    tmo                = 1'b0;
    emerg_log          = 1'b0;
    crit               = 1'b0;

    case (item.kind)
      KIND_TICK: begin
        if (initialized) begin
          if (emerg_pending) begin
            emerg_pending_next = 1'b0;
            emerg_log          = 1'b1;
            last_change_next   = now;
          end
          if ((seq != SEQ_REST) && (step_age > TIME_BITS'(cfg.step_timeout_ms))) begin
            relays_next      = relays_next & ~RELAY_POWER;
            seq_next         = SEQ_REST;
            last_change_next = now;
            tmo              = 1'b1;
          end
          unique case (seq_next)
            SEQ_EN_MAIN: begin
              relays_next[RLY_MAIN] = 1'b1;
              if (step_age >= TIME_BITS'(cfg.enable_step_ms)) begin
                seq_next        = SEQ_EN_TRAC;
                step_start_next = now;
              end
            end
            SEQ_EN_TRAC: begin
              relays_next[RLY_TRAC] = 1'b1;
              if (step_age >= TIME_BITS'(cfg.enable_step_ms)) begin
                seq_next        = SEQ_EN_STEER;
                step_start_next = now;
              end
            end
            SEQ_EN_STEER: begin
              relays_next[RLY_STEER] = 1'b1;
              seq_next               = SEQ_EN_END;
              step_start_next        = now;
            end
            SEQ_DIS_STEER: begin
              relays_next[RLY_STEER] = 1'b0;
              if (step_age >= TIME_BITS'(cfg.disable_step_ms)) begin
                seq_next        = SEQ_DIS_TRAC;
                step_start_next = now;
              end
            end
            SEQ_DIS_TRAC: begin
              relays_next[RLY_TRAC] = 1'b0;
              if (step_age >= TIME_BITS'(cfg.disable_step_ms)) begin
                seq_next        = SEQ_DIS_MAIN;
                step_start_next = now;
              end
            end
            SEQ_DIS_MAIN: begin
              relays_next[RLY_MAIN] = 1'b0;
              seq_next              = SEQ_DIS_END;
              step_start_next       = now;
            end
            SEQ_EN_END, SEQ_DIS_END: begin
              last_change_next = now;
              seq_next         = SEQ_REST;
            end
            default: seq_next = SEQ_REST;
          endcase

          mask = sensor_mask;
          if (mask != 7'd0) begin
            fault_count_next = (fault_count < FaultRunMax) ? fault_count + 8'd1 : fault_count;
            last_fault_next  = now;
            if (fault_count_next >= FaultRunMin) begin
              crit = 1'b1;
              if (seq_next == SEQ_REST) begin
                seq_next        = SEQ_DIS_STEER;
                step_start_next = now;
              end
            end
          end else if (fault_age > TIME_BITS'(FaultClearMs)) begin
            fault_count_next = '0;
          end
        end
      end
      KIND_ENABLE: begin
        priority if (!initialized) begin
          status = STAT_NO_INIT;
        end else if (item.system_has_error) begin
          status = STAT_SYS_ERR;
        end else if (change_age < TIME_BITS'(cfg.debounce_ms)) begin
          status = STAT_DEBOUNCE;
        end else if ((relays & RELAY_POWER) == RELAY_POWER) begin
          status           = STAT_ALREADY;
          last_change_next = now;
        end else if (seq != SEQ_REST) begin
          status = STAT_BUSY;
        end else begin
          seq_next        = SEQ_EN_MAIN;
          step_start_next = now;
        end
      end
      KIND_DISABLE: begin
        priority if (!initialized) begin
          status = STAT_NO_INIT;
        end else if (change_age < TIME_BITS'(cfg.debounce_ms)) begin
          status = STAT_DEBOUNCE;
        end else if ((relays & RELAY_POWER) == 5'd0) begin
          status           = STAT_ALREADY;
          last_change_next = now;
        end else if (seq != SEQ_REST) begin
          status = STAT_BUSY;
        end else begin
          seq_next        = SEQ_DIS_STEER;
          step_start_next = now;
        end
      end
      KIND_ESTOP: begin
        relays_next        = '0;
        seq_next           = SEQ_REST;
        emerg_pending_next = 1'b1;
      end
      KIND_LIGHTS: begin
        if (!initialized) begin
          status = STAT_NO_INIT;
        end else begin
          relays_next[RLY_LIGHT] = item.switch_on;
        end
      end
      KIND_MEDIA: begin
        if (!initialized) begin
          status = STAT_NO_INIT;
        end else begin
          relays_next[RLY_MEDIA] = item.switch_on;
        end
      end
      KIND_INIT: begin
        relays_next      = '0;
        last_change_next = now;
        seq_next         = SEQ_REST;
        initialized_next = 1'b1;
      end
      default: status = STAT_OK;
    endcase

    result.main_on           = relays_next[RLY_MAIN];
    result.traction_on       = relays_next[RLY_TRAC];
    result.steering_on       = relays_next[RLY_STEER];
    result.lights_on         = relays_next[RLY_LIGHT];
    result.media_on          = relays_next[RLY_MEDIA];
    result.sequence_step     = seq_next;
    result.request_status    = status;
    result.fault_mask        = mask;
    result.timeout_fired     = tmo;
    result.emergency_logged  = emerg_log;
    result.critical_shutdown = crit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initialized   <= 1'b0;
      seq           <= SEQ_REST;
      step_start    <= '0;
      last_change   <= '0;
      relays        <= '0;
      emerg_pending <= 1'b0;
      fault_count   <= '0;
      last_fault    <= '0;
    end else if (go) begin
      initialized   <= initialized_next;
      seq           <= seq_next;
      step_start    <= step_start_next;
      last_change   <= last_change_next;
      relays        <= relays_next;
      emerg_pending <= emerg_pending_next;
      fault_count   <= fault_count_next;
      last_fault    <= last_fault_next;
    end
  end

endmodule
`default_nettype wire

### rtl/relay_power_sequencer.sv
// relay power sequencer top level: input register, step logic, result register
// an accepted item is registered in the input register, and its result then in the result register
// throughput: one item per cycle while m_axis_tready holds, set by the combinational step logic
// the input register refills in the cycle it empties, so tready stays high under steady flow
// reset (rst, synchronous, active high) clears the valid bits of both registers, the sequencer state
// and loads the default limits and timings into the configuration registers
`default_nettype none
module relay_power_sequencer
  import rps_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // input item stream
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // now_ms[31:0], system_has_error[32], switch_on[33], battery_current[53:34],
  // battery_voltage[73:54], motor_temp_a[93:74], motor_temp_b[113:94],
  // motor_temp_c[133:114], motor_temp_d[153:134], zero fill[159:154]
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  // kind[2:0]
  input  wire logic [2:0]       s_axis_tuser,
  // result item stream
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // main_on[0], traction_on[1], steering_on[2], lights_on[3], media_on[4],
  // sequence_step[8:5], request_status[11:9], fault_mask[18:12],
  // timeout_fired[19], emergency_logged[20], critical_shutdown[21], zero fill[23:22]
  output logic [OUT_W-1:0]      m_axis_tdata,
  // configuration write port
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cfg_t       cfg;
  item_t      in_item;
  logic       in_valid;
  logic       advance;
  logic [6:0] sensor_mask;
  result_t    step_result;
  result_t    out_result;

  // an item moves on when the result register is empty or being drained
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // input register: unpack the stream fields once on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.kind             <= s_axis_tuser;
      in_item.now_ms           <= s_axis_tdata[31:0];
      in_item.system_has_error <= s_axis_tdata[32];
      in_item.switch_on        <= s_axis_tdata[33];
      in_item.battery_current  <= $signed(s_axis_tdata[53:34]);
      in_item.battery_voltage  <= $signed(s_axis_tdata[73:54]);
      in_item.motor_temp[0]    <= s_axis_tdata[93:74];
      in_item.motor_temp[1]    <= s_axis_tdata[113:94];
      in_item.motor_temp[2]    <= s_axis_tdata[133:114];
      in_item.motor_temp[3]    <= s_axis_tdata[153:134];
    end
  end

  rps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sensor compares run on every item; the core only uses them on ticks
  rps_fault_check u_fault (
    .cfg        (cfg),
    .item       (in_item),
    .fault_mask (sensor_mask)
  );

  rps_seq_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .go          (advance),
    .cfg         (cfg),
    .item        (in_item),
    .sensor_mask (sensor_mask),
    .result      (step_result)
  );

  // result register: holds a finished item until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tdata = {2'b00, out_result};

endmodule
`default_nettype wire

### rtl/rps_checker.sv
// port-level checks of the relay power sequencer and their bind
`default_nettype none
module rps_checker
  import rps_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // nothing comes out in the cycle after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // only a tick can report sensor faults, and ticks carry no request status
  a_fault_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[18:12] != 7'd0) |-> m_axis_tdata[11:9] == STAT_OK)
    else $error("fault mask with a request status");

  // a critical shutdown needs a fault on the same tick and never leaves the sequencer at rest
  a_crit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[21] |->
      (m_axis_tdata[18:12] != 7'd0) && (m_axis_tdata[8:5] != SEQ_REST))
    else $error("critical shutdown without a fault or with the sequencer at rest");

  // an empty result register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty result register");

endmodule

bind relay_power_sequencer rps_checker u_rps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
